// File: design/spdu_pkg.sv
// ----------------------------------------------------------------------------
// spdu_pkg: shared types and codes for the signal PDU packer and scheduler
// Command codes, result kinds, field widths and the classified request record.
// ----------------------------------------------------------------------------
package spdu_pkg;

  localparam int DEF_NUM_PDUS      = 4;
  localparam int DEF_NUM_SIGNALS   = 16;
  localparam int DEF_PDU_BYTES     = 8;
  localparam int DEF_MAX_MAP_SLOTS = 8;
  localparam int DEF_ID_START_BIT  = 0;
  localparam int DEF_TICK_MS       = 5;

  localparam int MAX_RESULTS = 32;

  localparam logic [2:0] CMD_WRITE   = 3'd0;
  localparam logic [2:0] CMD_READ    = 3'd1;
  localparam logic [2:0] CMD_TRIGGER = 3'd2;
  localparam logic [2:0] CMD_TICK    = 3'd3;
  localparam logic [2:0] CMD_STAGE   = 3'd4;
  localparam logic [2:0] CMD_LOADPDU = 3'd5;
  localparam logic [2:0] CMD_LOADMAP = 3'd6;
  localparam logic [2:0] CMD_SPARE   = 3'd7;

  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_BYTE = 2'd2;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 48;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  sig;
    logic [31:0] sval;
    logic [1:0]  pdu;
    logic [2:0]  slot;
    logic [7:0]  byte_val;
    logic        dir;
    logic        per;
    logic [15:0] pms;
    logic [3:0]  cnt;
    logic [5:0]  bst;
    logic [3:0]  bw;
    logic        sig_ok;
    logic        pdu_ok;
    logic        stage_ok;
    logic        map_ok;
  } req_t;

  typedef struct packed {
    logic idle;
    logic ticking;
  } bk_status_t;

endpackage

// File: design/signal_pdu_packer_scheduler_core.sv
// ----------------------------------------------------------------------------
// signal_pdu_packer_scheduler_core: signal store with PDU packing scheduler
// Requests enter on the in_ stream and results leave on the out_ stream.
// ----------------------------------------------------------------------------
// Each request carries its command in in_tuser and its operands in in_tdata.
// Every request gives one result except a tick that sends PDUs, which gives
// one byte result per emitted PDU byte; out_tlast marks the final result of
// each request and out_tuser gives the result kind.
// A two-entry queue takes requests while the executing side is busy; the
// executing side carries out one request at a time.
// Simple commands pass from the queue through the acknowledge or read state
// into the output register. A descriptor load passes through one more state,
// for the reciprocal multiplication that turns the period into ticks. A tick
// reads each mapped slot of a due PDU, emits the bytes of each due send PDU
// and an acknowledge when nothing is sent; the sequencer reads one map slot
// and one signal or frame byte at a time.
// Reset clears the queue, the descriptors and the valid bits of the signal
// store, map slots and frame bytes, so they read as their reset values.
// When the receiver stalls, the finished result is held in the output
// register and the sequencer waits; the queue takes requests until full.
// ----------------------------------------------------------------------------
module signal_pdu_packer_scheduler_core
  import spdu_pkg::*;
#(
  parameter int NUM_PDUS      = DEF_NUM_PDUS,
  parameter int NUM_SIGNALS   = DEF_NUM_SIGNALS,
  parameter int PDU_BYTES     = DEF_PDU_BYTES,
  parameter int MAX_MAP_SLOTS = DEF_MAX_MAP_SLOTS,
  parameter int ID_START_BIT  = DEF_ID_START_BIT,
  parameter int TICK_MS       = DEF_TICK_MS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // signal_index, signal_value, pdu_index, slot_index, byte_value,
  // send_direction, periodic_mode, period_ms, signal_count, bit_start, bit_width
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // command
  input  logic [2:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_pdu, out_byte_index, out_byte, read_value
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // result_kind
  output logic [1:0]             out_tuser,
  output logic                   out_tlast
);

  logic       q_valid;
  req_t       q_data;
  logic       q_pop;
  bk_status_t bk_st;

  spdu_front #(
    .NUM_PDUS     (NUM_PDUS),
    .NUM_SIGNALS  (NUM_SIGNALS),
    .PDU_BYTES    (PDU_BYTES),
    .MAX_MAP_SLOTS(MAX_MAP_SLOTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  spdu_back #(
    .NUM_PDUS     (NUM_PDUS),
    .NUM_SIGNALS  (NUM_SIGNALS),
    .PDU_BYTES    (PDU_BYTES),
    .MAX_MAP_SLOTS(MAX_MAP_SLOTS),
    .ID_START_BIT (ID_START_BIT),
    .TICK_MS      (TICK_MS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .status    (bk_st),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

`ifndef SYNTHESIS
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("queue popped while empty");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> bk_st.idle) else $error("request taken while executing");

  a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !q_pop) |=> q_valid)
    else $error("accepted request lost from queue");

  a_tick_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    bk_st.ticking |-> !q_pop) else $error("request taken during a tick");
`endif

endmodule

// File: design/spdu_front.sv
// ----------------------------------------------------------------------------
// spdu_front: request intake and classification
// Unpacks each request, range-checks its indexes, clamps its counts and
// widths, and holds it in a two-entry queue for the execution side.
// ----------------------------------------------------------------------------
module spdu_front
  import spdu_pkg::*;
#(
  parameter int NUM_PDUS      = DEF_NUM_PDUS,
  parameter int NUM_SIGNALS   = DEF_NUM_SIGNALS,
  parameter int PDU_BYTES     = DEF_PDU_BYTES,
  parameter int MAX_MAP_SLOTS = DEF_MAX_MAP_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [2:0]            in_tuser,
  output logic                  q_valid,
  output req_t                  q_data,
  input  logic                  q_pop
);

  req_t       cls;
  req_t       ent_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  always_comb begin
    cls.cmd      = in_tuser;
    cls.sig      = in_tdata[3:0];
    cls.sval     = in_tdata[35:4];
    cls.pdu      = in_tdata[37:36];
    cls.slot     = in_tdata[40:38];
    cls.byte_val = in_tdata[48:41];
    cls.dir      = in_tdata[49];
    cls.per      = in_tdata[50];
    cls.pms      = in_tdata[66:51];
    cls.cnt      = (32'(in_tdata[70:67]) > MAX_MAP_SLOTS) ? 4'(MAX_MAP_SLOTS) : in_tdata[70:67];
    cls.bst      = in_tdata[76:71];
    if (in_tdata[80:77] == 4'd0) begin
      cls.bw = 4'd1;
    end else if (in_tdata[80:77] > 4'd8) begin
      cls.bw = 4'd8;
    end else begin
      cls.bw = in_tdata[80:77];
    end
    cls.sig_ok   = 32'(in_tdata[3:0]) < NUM_SIGNALS;
    cls.pdu_ok   = 32'(in_tdata[37:36]) < NUM_PDUS;
    cls.stage_ok = 32'(in_tdata[40:38]) < PDU_BYTES;
    cls.map_ok   = 32'(in_tdata[40:38]) < MAX_MAP_SLOTS;
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_data    = ent_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = 2'(cnt_r + {1'b0, push} - {1'b0, q_pop});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= cls;
    end
  end

endmodule

// File: design/spdu_back.sv
// ----------------------------------------------------------------------------
// spdu_back: command execution and tick sequencer
// Holds the signal store, PDU descriptors, map slots and frame bytes, runs
// the period division, walks PDUs and map slots on a tick and drives results.
// ----------------------------------------------------------------------------
module spdu_back
  import spdu_pkg::*;
#(
  parameter int NUM_PDUS      = DEF_NUM_PDUS,
  parameter int NUM_SIGNALS   = DEF_NUM_SIGNALS,
  parameter int PDU_BYTES     = DEF_PDU_BYTES,
  parameter int MAX_MAP_SLOTS = DEF_MAX_MAP_SLOTS,
  parameter int ID_START_BIT  = DEF_ID_START_BIT,
  parameter int TICK_MS       = DEF_TICK_MS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  req_t                   q_data,
  output logic                   q_pop,
  output bk_status_t             status,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]             out_tuser,
  output logic                   out_tlast
);

  localparam int PW        = (NUM_PDUS > 1) ? $clog2(NUM_PDUS) : 1;
  localparam int SAW       = (NUM_SIGNALS > 1) ? $clog2(NUM_SIGNALS) : 1;
  localparam int BIW       = (PDU_BYTES > 1) ? $clog2(PDU_BYTES) : 1;
  localparam int MAP_DEPTH = NUM_PDUS * MAX_MAP_SLOTS;
  localparam int MAW       = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int FRM_DEPTH = NUM_PDUS * PDU_BYTES;
  localparam int FAW       = (FRM_DEPTH > 1) ? $clog2(FRM_DEPTH) : 1;
  localparam int RCP_SH    = 16 + $clog2(TICK_MS);
  localparam longint unsigned RCP_MUL =
    ((longint'(1) << RCP_SH) + longint'(TICK_MS) - 1) / longint'(TICK_MS);
  localparam int ID_BYTE   = ID_START_BIT / 8;
  localparam int ID_SH     = ID_START_BIT % 8;
  localparam bit ID_OK     = ID_BYTE < PDU_BYTES;
  localparam int ID_IDX    = ID_OK ? ID_BYTE : 0;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ACK  = 4'd1;
  localparam logic [3:0] S_RDD  = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_PDU  = 4'd4;
  localparam logic [3:0] S_MAP  = 4'd5;
  localparam logic [3:0] S_MAPD = 4'd6;
  localparam logic [3:0] S_SIGD = 4'd7;
  localparam logic [3:0] S_FRMD = 4'd8;
  localparam logic [3:0] S_EMIT = 4'd9;

  typedef struct packed {
    logic [3:0] sig;
    logic [5:0] start;
    logic [3:0] width;
  } map_ent_t;

  // Signal store, map slots and frame bytes.
  logic [31:0] sig_mem [NUM_SIGNALS];
  logic [NUM_SIGNALS-1:0] sig_vld_r;
  logic [31:0] sig_rd_r;
  logic        sig_rv_r;
  logic        sig_we, sig_re;
  logic [SAW-1:0] sig_wa, sig_ra;
  logic [31:0] sig_wd;

  map_ent_t map_mem [MAP_DEPTH];
  logic [MAP_DEPTH-1:0] map_vld_r;
  map_ent_t map_rd_r;
  logic     map_rv_r;
  logic     map_we, map_re;
  logic [MAW-1:0] map_wa, map_ra;
  map_ent_t map_wd, mv;

  logic [7:0] frm_mem [FRM_DEPTH];
  logic [FRM_DEPTH-1:0] frm_vld_r;
  logic [7:0] frm_rd_r;
  logic       frm_rv_r;
  logic       frm_we, frm_re;
  logic [FAW-1:0] frm_wa, frm_ra;
  logic [7:0] frm_wd;

  // PDU descriptors.
  logic        is_send_r [NUM_PDUS];
  logic        is_per_r  [NUM_PDUS];
  logic [7:0]  ident_r   [NUM_PDUS];
  logic [15:0] period_r  [NUM_PDUS];
  logic [15:0] cd_r      [NUM_PDUS];
  logic        pend_r    [NUM_PDUS];
  logic [3:0]  mcnt_r    [NUM_PDUS];

  logic [3:0]  st_r, st_nxt;
  req_t        req_r, req_nxt;
  logic [PW-1:0] p_r, p_nxt;
  logic        pass_r, pass_nxt;
  logic [4:0]  i_r, i_nxt;
  logic [2:0]  b_r, b_nxt;
  logic [5:0]  n_r, n_nxt;
  logic        sent_r, sent_nxt;
  logic [NUM_PDUS-1:0] due_r, due_nxt;
  logic [PDU_BYTES-1:0][7:0] frame_r, frame_nxt;
  logic [15:0] div_q_r, div_q_nxt;
  logic [32:0] div_prod;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_kind_r, out_kind_nxt;
  logic [1:0]  out_pdu_r, out_pdu_nxt;
  logic [2:0]  out_bidx_r, out_bidx_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic [31:0] out_val_r, out_val_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_load;

  logic        pend_set, desc_we, upd_en, upd_due;
  logic        adv, mine, due_cur, hi_due;
  logic [31:0] sv;
  logic [7:0]  fb, wmask;

  assign mv = map_rv_r ? map_rd_r : '{sig: 4'd0, start: 6'd0, width: 4'd1};
  assign sv = sig_rv_r ? sig_rd_r : 32'd0;
  assign fb = frm_rv_r ? frm_rd_r : 8'd0;
  assign out_load = !out_valid_r || out_tready;
  assign div_prod = {17'd0, q_data.pms} * 33'(RCP_MUL);

  always_comb begin
    mine    = (is_send_r[p_r] != pass_r);
    due_cur = is_per_r[p_r] ? (cd_r[p_r] == 16'd0) : pend_r[p_r];
    hi_due  = 1'b0;
    for (int k = 0; k < NUM_PDUS; k++) begin
      if (k > int'(p_r) && due_r[k]) begin
        hi_due = 1'b1;
      end
    end
    wmask  = 8'((9'd1 << mv.width) - 9'd1);
  end

  always_comb begin
    st_nxt       = st_r;
    req_nxt      = req_r;
    p_nxt        = p_r;
    pass_nxt     = pass_r;
    i_nxt        = i_r;
    b_nxt        = b_r;
    n_nxt        = n_r;
    sent_nxt     = sent_r;
    due_nxt      = due_r;
    frame_nxt    = frame_r;
    div_q_nxt    = div_q_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt = out_kind_r;
    out_pdu_nxt  = out_pdu_r;
    out_bidx_nxt = out_bidx_r;
    out_byte_nxt = out_byte_r;
    out_val_nxt  = out_val_r;
    out_last_nxt = out_last_r;
    q_pop    = 1'b0;
    sig_we   = 1'b0;
    sig_wa   = SAW'(q_data.sig);
    sig_wd   = q_data.sval;
    sig_re   = 1'b0;
    sig_ra   = SAW'(q_data.sig);
    map_we   = 1'b0;
    map_wa   = MAW'(int'(q_data.pdu) * MAX_MAP_SLOTS + int'(q_data.slot));
    map_wd   = '{sig: q_data.sig, start: q_data.bst, width: q_data.bw};
    map_re   = 1'b0;
    map_ra   = MAW'(int'(p_r) * MAX_MAP_SLOTS + int'(i_r));
    frm_we   = 1'b0;
    frm_wa   = FAW'(int'(q_data.pdu) * PDU_BYTES + int'(q_data.slot));
    frm_wd   = q_data.byte_val;
    frm_re   = 1'b0;
    frm_ra   = FAW'(int'(p_r) * PDU_BYTES + int'(mv.start[5:3]));
    pend_set = 1'b0;
    desc_we  = 1'b0;
    upd_en   = 1'b0;
    upd_due  = due_cur;
    adv      = 1'b0;

    unique case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          req_nxt = q_data;
          st_nxt  = S_ACK;
          unique case (q_data.cmd)
            CMD_WRITE:   sig_we = q_data.sig_ok;
            CMD_READ: begin
              sig_re = q_data.sig_ok;
              st_nxt = S_RDD;
            end
            CMD_TRIGGER: pend_set = q_data.pdu_ok;
            CMD_TICK: begin
              for (int k = 0; k < NUM_PDUS; k++) begin
                due_nxt[k] = is_send_r[k] && (is_per_r[k] ? (cd_r[k] == 16'd0) : pend_r[k]);
              end
              p_nxt    = '0;
              pass_nxt = 1'b0;
              n_nxt    = '0;
              sent_nxt = 1'b0;
              st_nxt   = S_PDU;
            end
            CMD_STAGE:   frm_we = q_data.pdu_ok && q_data.stage_ok;
            CMD_LOADPDU: begin
              if (q_data.pdu_ok) begin
                div_q_nxt = 16'(div_prod >> RCP_SH);
                st_nxt    = S_DIV;
              end
            end
            CMD_LOADMAP: map_we = q_data.pdu_ok && q_data.map_ok;
            default: ;
          endcase
        end
      end
      S_ACK: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_ACK;
          out_pdu_nxt   = '0;
          out_bidx_nxt  = '0;
          out_byte_nxt  = '0;
          out_val_nxt   = '0;
          out_last_nxt  = 1'b1;
          st_nxt        = S_IDLE;
        end
      end
      S_RDD: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_READ;
          out_pdu_nxt   = '0;
          out_bidx_nxt  = '0;
          out_byte_nxt  = '0;
          out_val_nxt   = req_r.sig_ok ? sv : 32'd0;
          out_last_nxt  = 1'b1;
          st_nxt        = S_IDLE;
        end
      end
      S_DIV: begin
        desc_we = 1'b1;
        st_nxt  = S_ACK;
      end
      S_PDU: begin
        if (mine) begin
          upd_en = 1'b1;
          if (due_cur) begin
            i_nxt = '0;
            if (!pass_r) begin
              frame_nxt = '0;
              if (ID_OK) begin
                frame_nxt[ID_IDX] = 8'(ident_r[p_r] << ID_SH);
              end
            end
            st_nxt = S_MAP;
          end else begin
            adv = 1'b1;
          end
        end else begin
          adv = 1'b1;
        end
      end
      S_MAP: begin
        if (i_r < {1'b0, mcnt_r[p_r]}) begin
          map_re = 1'b1;
          st_nxt = S_MAPD;
        end else if (!pass_r) begin
          b_nxt  = '0;
          st_nxt = S_EMIT;
        end else begin
          adv = 1'b1;
        end
      end
      S_MAPD: begin
        if (!pass_r) begin
          sig_re = 1'b1;
          sig_ra = SAW'(mv.sig);
          st_nxt = S_SIGD;
        end else begin
          frm_re = 1'b1;
          st_nxt = S_FRMD;
        end
      end
      S_SIGD: begin
        if (32'(mv.start[5:3]) < PDU_BYTES && 32'(mv.sig) < NUM_SIGNALS) begin
          frame_nxt[BIW'(mv.start[5:3])] = frame_r[BIW'(mv.start[5:3])] |
                                            8'(sv << mv.start[2:0]);
        end
        i_nxt  = 5'(i_r + 5'd1);
        st_nxt = S_MAP;
      end
      S_FRMD: begin
        if (32'(mv.start[5:3]) < PDU_BYTES && 32'(mv.sig) < NUM_SIGNALS) begin
          sig_we = 1'b1;
          sig_wa = SAW'(mv.sig);
          sig_wd = {24'd0, (fb >> mv.start[2:0]) & wmask};
        end
        i_nxt  = 5'(i_r + 5'd1);
        st_nxt = S_MAP;
      end
      S_EMIT: begin
        if (n_r == 6'(MAX_RESULTS) || out_load) begin
          frm_we = 1'b1;
          frm_wa = FAW'(int'(p_r) * PDU_BYTES + int'(b_r));
          frm_wd = frame_r[BIW'(b_r)];
          if (n_r != 6'(MAX_RESULTS)) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_BYTE;
            out_pdu_nxt   = 2'(p_r);
            out_bidx_nxt  = b_r;
            out_byte_nxt  = frame_r[BIW'(b_r)];
            out_val_nxt   = '0;
            out_last_nxt  = (n_r == 6'(MAX_RESULTS - 1)) ||
                            (b_r == 3'(PDU_BYTES - 1) && !hi_due);
            n_nxt         = 6'(n_r + 6'd1);
            sent_nxt      = 1'b1;
          end
          if (b_r == 3'(PDU_BYTES - 1)) begin
            adv = 1'b1;
          end else begin
            b_nxt = 3'(b_r + 3'd1);
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase

    if (adv) begin
      if (p_r == PW'(NUM_PDUS - 1)) begin
        p_nxt = '0;
        if (!pass_r) begin
          pass_nxt = 1'b1;
          st_nxt   = S_PDU;
        end else begin
          st_nxt = sent_nxt ? S_IDLE : S_ACK;
        end
      end else begin
        p_nxt  = PW'(p_r + PW'(1));
        st_nxt = S_PDU;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    p_r        <= p_nxt;
    pass_r     <= pass_nxt;
    i_r        <= i_nxt;
    b_r        <= b_nxt;
    n_r        <= n_nxt;
    sent_r     <= sent_nxt;
    due_r      <= due_nxt;
    frame_r    <= frame_nxt;
    div_q_r    <= div_q_nxt;
    out_kind_r <= out_kind_nxt;
    out_pdu_r  <= out_pdu_nxt;
    out_bidx_r <= out_bidx_nxt;
    out_byte_r <= out_byte_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_PDUS; k++) begin
        is_send_r[k] <= 1'b0;
        is_per_r[k]  <= 1'b0;
        ident_r[k]   <= 8'd0;
        period_r[k]  <= 16'd0;
        cd_r[k]      <= 16'd0;
        pend_r[k]    <= 1'b0;
        mcnt_r[k]    <= 4'd0;
      end
    end else begin
      if (pend_set) begin
        pend_r[PW'(q_data.pdu)] <= 1'b1;
      end
      if (desc_we) begin
        is_send_r[PW'(req_r.pdu)] <= req_r.dir;
        is_per_r[PW'(req_r.pdu)]  <= req_r.per;
        ident_r[PW'(req_r.pdu)]   <= req_r.byte_val;
        period_r[PW'(req_r.pdu)]  <= div_q_r;
        cd_r[PW'(req_r.pdu)]      <= 16'd0;
        pend_r[PW'(req_r.pdu)]    <= 1'b0;
        mcnt_r[PW'(req_r.pdu)]    <= req_r.cnt;
      end
      if (upd_en) begin
        if (is_per_r[p_r]) begin
          cd_r[p_r] <= 16'((upd_due ? period_r[p_r] : cd_r[p_r]) - 16'd1);
        end else if (upd_due) begin
          pend_r[p_r] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_vld_r <= '0;
      map_vld_r <= '0;
      frm_vld_r <= '0;
    end else begin
      if (sig_we) sig_vld_r[sig_wa] <= 1'b1;
      if (map_we) map_vld_r[map_wa] <= 1'b1;
      if (frm_we) frm_vld_r[frm_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sig_we) sig_mem[sig_wa] <= sig_wd;
    if (sig_re) begin
      sig_rd_r <= sig_mem[sig_ra];
      sig_rv_r <= sig_vld_r[sig_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    if (map_re) begin
      map_rd_r <= map_mem[map_ra];
      map_rv_r <= map_vld_r[map_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (frm_we) frm_mem[frm_wa] <= frm_wd;
    if (frm_re) begin
      frm_rd_r <= frm_mem[frm_ra];
      frm_rv_r <= frm_vld_r[frm_ra];
    end
  end

  assign status.idle    = (st_r == S_IDLE);
  assign status.ticking = (st_r == S_PDU) || (st_r == S_MAP) || (st_r == S_MAPD) ||
                          (st_r == S_SIGD) || (st_r == S_FRMD) || (st_r == S_EMIT);

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_val_r, out_byte_r, out_bidx_r, out_pdu_r};

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the signal PDU packer and scheduler core
// Requests are driven on the in_ stream and every result on the out_ stream
// is checked against an in-bench model of the signal store and PDU scheduler.
// ----------------------------------------------------------------------------
module tb;
  import spdu_pkg::*;

  localparam int NPDU  = DEF_NUM_PDUS;
  localparam int NSIG  = DEF_NUM_SIGNALS;
  localparam int NBYTE = DEF_PDU_BYTES;
  localparam int NSLOT = DEF_MAX_MAP_SLOTS;
  localparam int LIMIT = 1000000;

  typedef struct {
    logic [2:0]  cmd;
    logic [3:0]  sig;
    logic [31:0] sval;
    logic [1:0]  pdu;
    logic [2:0]  slot;
    logic [7:0]  bval;
    logic        dir;
    logic        per;
    logic [15:0] pms;
    logic [3:0]  cnt;
    logic [5:0]  bst;
    logic [3:0]  bw;
  } request_t;

  typedef struct {
    logic [1:0]  kind;
    logic [1:0]  pdu;
    logic [2:0]  idx;
    logic [7:0]  bval;
    logic [31:0] val;
    logic        last;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;

  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  reply_t reply_queue[$];

  logic [31:0] sig_store [NSIG];
  logic        is_send [NPDU];
  logic        is_periodic [NPDU];
  logic [7:0]  ident [NPDU];
  logic [15:0] period_ticks [NPDU];
  logic [15:0] countdown [NPDU];
  logic        pending [NPDU];
  logic [3:0]  map_count [NPDU];
  logic [3:0]  map_sig [NPDU*NSLOT];
  logic [5:0]  map_start [NPDU*NSLOT];
  logic [3:0]  map_width [NPDU*NSLOT];
  logic [7:0]  frame [NPDU*NBYTE];

  signal_pdu_packer_scheduler_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (reply_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind %0d data %h last %0b", $time,
                 out_tuser, out_tdata, out_tlast);
      end else begin
        want = reply_queue.pop_front();
        if (out_tuser !== want.kind || out_tdata[1:0] !== want.pdu ||
            out_tdata[4:2] !== want.idx || out_tdata[12:5] !== want.bval ||
            out_tdata[44:13] !== want.val || out_tlast !== want.last) begin
          errors++;
          $display("%0t: expected kind %0d pdu %0d idx %0d byte %h val %h last %0b",
                   $time, want.kind, want.pdu, want.idx, want.bval, want.val, want.last);
          $display("%0t: actual   kind %0d pdu %0d idx %0d byte %h val %h last %0b",
                   $time, out_tuser, out_tdata[1:0], out_tdata[4:2], out_tdata[12:5],
                   out_tdata[44:13], out_tlast);
        end
      end
    end
  end

  task automatic push_reply(input logic [1:0] kind, input logic [1:0] pdu,
                            input logic [2:0] idx, input logic [7:0] bval,
                            input logic [31:0] val, input logic last);
    reply_t r;
    r.kind = kind; r.pdu = pdu; r.idx = idx; r.bval = bval; r.val = val; r.last = last;
    reply_queue.push_back(r);
  endtask

  function automatic logic is_due(input int p);
    if (is_periodic[p]) return countdown[p] == 16'd0;
    return pending[p];
  endfunction

  function automatic void advance_timer(input int p, input logic due);
    if (is_periodic[p]) begin
      if (due) countdown[p] = period_ticks[p];
      countdown[p] = countdown[p] - 16'd1;
    end else if (due) begin
      pending[p] = 1'b0;
    end
  endfunction

  function automatic void reset_model();
    foreach (sig_store[i]) sig_store[i] = '0;
    for (int p = 0; p < NPDU; p++) begin
      is_send[p] = 0; is_periodic[p] = 0; ident[p] = 0; period_ticks[p] = 0;
      countdown[p] = 0; pending[p] = 0; map_count[p] = 0;
    end
    for (int m = 0; m < NPDU*NSLOT; m++) begin
      map_sig[m] = 0; map_start[m] = 0; map_width[m] = 1;
    end
    foreach (frame[i]) frame[i] = '0;
  endfunction

  task automatic predict_tick();
    int n;
    int m;
    logic due;
    logic [31:0] shifted;
    logic [31:0] mask;
    n = 0;
    for (int p = 0; p < NPDU; p++) begin
      if (is_send[p]) begin
        due = is_due(p);
        if (due) begin
          for (int b = 0; b < NBYTE; b++) frame[p*NBYTE+b] = '0;
          frame[p*NBYTE] |= ident[p];
          for (int i = 0; i < map_count[p] && i < NSLOT; i++) begin
            m = p*NSLOT + i;
            shifted = sig_store[map_sig[m]] << map_start[m][2:0];
            frame[p*NBYTE + map_start[m][5:3]] |= shifted[7:0];
          end
          for (int b = 0; b < NBYTE; b++) begin
            push_reply(KIND_BYTE, 2'(p), 3'(b), frame[p*NBYTE+b], '0, 1'b0);
            n++;
          end
        end
        advance_timer(p, due);
      end
    end
    for (int p = 0; p < NPDU; p++) begin
      if (!is_send[p]) begin
        due = is_due(p);
        if (due) begin
          for (int i = 0; i < map_count[p] && i < NSLOT; i++) begin
            m = p*NSLOT + i;
            mask = (32'd1 << map_width[m]) - 32'd1;
            sig_store[map_sig[m]] =
              ({24'd0, frame[p*NBYTE + map_start[m][5:3]]} >> map_start[m][2:0]) & mask;
          end
        end
        advance_timer(p, due);
      end
    end
    if (n > 0) reply_queue[$].last = 1'b1;
    else push_reply(KIND_ACK, '0, '0, '0, '0, 1'b1);
  endtask

  task automatic apply_command(input request_t q);
    case (q.cmd)
      CMD_WRITE: sig_store[q.sig] = q.sval;
      CMD_READ: begin
        push_reply(KIND_READ, '0, '0, '0, sig_store[q.sig], 1'b1);
        return;
      end
      CMD_TRIGGER: pending[q.pdu] = 1'b1;
      CMD_TICK: begin
        predict_tick();
        return;
      end
      CMD_STAGE: frame[q.pdu*NBYTE + q.slot] = q.bval;
      CMD_LOADPDU: begin
        is_send[q.pdu] = q.dir;
        is_periodic[q.pdu] = q.per;
        ident[q.pdu] = q.bval;
        period_ticks[q.pdu] = 16'(q.pms / DEF_TICK_MS);
        countdown[q.pdu] = '0;
        pending[q.pdu] = 1'b0;
        map_count[q.pdu] = (q.cnt > NSLOT) ? 4'(NSLOT) : q.cnt;
      end
      CMD_LOADMAP: begin
        map_sig[q.pdu*NSLOT + q.slot] = q.sig;
        map_start[q.pdu*NSLOT + q.slot] = q.bst;
        map_width[q.pdu*NSLOT + q.slot] = (q.bw == 4'd0) ? 4'd1 :
                                          ((q.bw > 4'd8) ? 4'd8 : q.bw);
      end
      default: ;
    endcase
    push_reply(KIND_ACK, '0, '0, '0, '0, 1'b1);
  endtask

  task automatic send_request(input request_t q);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser <= q.cmd;
    in_tdata <= {7'd0, q.bw, q.bst, q.cnt, q.pms, q.per, q.dir, q.bval, q.slot, q.pdu,
                 q.sval, q.sig};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_command(q);
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic request_t random_request();
    request_t q;
    int w;
    q.sig = 4'($urandom); q.sval = $urandom; q.pdu = 2'($urandom); q.slot = 3'($urandom);
    q.bval = 8'($urandom); q.dir = 1'($urandom); q.per = 1'($urandom);
    q.pms = 16'($urandom); q.cnt = 4'($urandom); q.bst = 6'($urandom);
    q.bw = 4'($urandom);
    if ($urandom_range(99) < 75) q.pms = 16'($urandom_range(0, 40));
    if ($urandom_range(99) < 70) q.cnt = 4'($urandom_range(1, 8));
    w = $urandom_range(99);
    if (w < 18) q.cmd = CMD_WRITE;
    else if (w < 32) q.cmd = CMD_READ;
    else if (w < 45) q.cmd = CMD_TRIGGER;
    else if (w < 68) q.cmd = CMD_TICK;
    else if (w < 78) q.cmd = CMD_STAGE;
    else if (w < 85) q.cmd = CMD_LOADPDU;
    else if (w < 97) q.cmd = CMD_LOADMAP;
    else q.cmd = CMD_SPARE;
    return q;
  endfunction

  function automatic request_t blank(input logic [2:0] cmd);
    request_t q;
    q = '{cmd: cmd, sig: 0, sval: 0, pdu: 0, slot: 0, bval: 0, dir: 0, per: 0,
          pms: 0, cnt: 0, bst: 0, bw: 1};
    return q;
  endfunction

  task automatic test_directed();
    request_t q;
    q = blank(CMD_READ); q.sig = 4'd15; send_request(q);
    q = blank(CMD_WRITE); q.sig = 4'd15; q.sval = 32'hFFFF_FFFF; send_request(q);
    q = blank(CMD_READ); q.sig = 4'd15; send_request(q);
    q = blank(CMD_WRITE); q.sval = 32'h0000_01A5; send_request(q);
    q = blank(CMD_TICK); send_request(q);
    q = blank(CMD_SPARE); send_request(q);
    q = blank(CMD_LOADPDU); q.pdu = 2'd3; q.dir = 1; q.bval = 8'hFF; q.cnt = 4'd15;
    send_request(q);
    q = blank(CMD_LOADMAP); q.pdu = 2'd3; q.slot = 3'd7; q.sig = 4'd15; q.bst = 6'd63;
    q.bw = 4'd0; send_request(q);
    q = blank(CMD_LOADMAP); q.pdu = 2'd3; q.slot = 3'd0; q.bst = 6'd5; q.bw = 4'd15;
    send_request(q);
    q = blank(CMD_TICK); send_request(q);
    q = blank(CMD_TRIGGER); q.pdu = 2'd3; send_request(q);
    q = blank(CMD_TICK); send_request(q);
    q = blank(CMD_LOADPDU); q.pdu = 2'd0; q.dir = 1; q.per = 1; q.pms = 16'd0;
    q.cnt = 4'd0; send_request(q);
    q = blank(CMD_TRIGGER); send_request(q);
    q = blank(CMD_TICK); send_request(q);
    q = blank(CMD_TICK); send_request(q);
    q = blank(CMD_LOADPDU); q.pdu = 2'd1; q.per = 1; q.pms = 16'hFFFF; q.cnt = 4'd8;
    send_request(q);
    q = blank(CMD_LOADMAP); q.pdu = 2'd1; q.slot = 3'd2; q.sig = 4'd3; q.bst = 6'd61;
    q.bw = 4'd8; send_request(q);
    q = blank(CMD_STAGE); q.pdu = 2'd1; q.slot = 3'd7; q.bval = 8'hFF; send_request(q);
    q = blank(CMD_TICK); send_request(q);
    q = blank(CMD_READ); q.sig = 4'd3; send_request(q);
    q = blank(CMD_READ); send_request(q);
  endtask

  task automatic test_random(input int count, input int send_idle, input int recv_stall);
    idle_pct = send_idle;
    stall_pct = recv_stall;
    for (int i = 0; i < count; i++) send_request(random_request());
    idle_pct = 0;
  endtask

  initial begin
    reset_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(80, 0, 0);
    test_random(80, 77, 0);
    test_random(80, 0, 77);
    test_random(80, 15, 15);
    in_tvalid <= 1'b0;
    stall_pct = 0;
    while (reply_queue.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
